// File: hw/rtl/taa_pkg.sv
// shared types, constants and helpers for the transformed bounding box accumulator
`default_nettype none

package taa_pkg;

    // coordinate width of results and of the running bounds
    localparam int CW = 16;
    // fixed input formats: 16-bit coordinates and 16-bit coefficients
    localparam int IN_W   = 16;
    localparam int COEF_W = 16;
    localparam int FRAC   = 8;
    localparam int PROD_W = IN_W + COEF_W;
    // three products plus the scaled translation need two more bits
    localparam int SUM_W  = PROD_W + 2;
    localparam int NAXES  = 3;
    localparam int NTERMS = 4;

    localparam int EPS_W      = 8;
    localparam int ROW_W      = NTERMS * COEF_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ROW_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    localparam logic [ROW_W-1:0] ROW_X_RST = 64'h0100_0000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 64'h0000_0100_0000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 64'h0000_0000_0100_0000;
    localparam logic [EPS_W-1:0] EPS_RST   = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X   = 2'd0,
        REG_ROW_Y   = 2'd1,
        REG_ROW_Z   = 2'd2,
        REG_EPSILON = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [IN_W-1:0] vertex_x;
        logic signed [IN_W-1:0] vertex_y;
        logic signed [IN_W-1:0] vertex_z;
        logic                   last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [CW-1:0] box_min_x;
        logic signed [CW-1:0] box_min_y;
        logic signed [CW-1:0] box_min_z;
        logic signed [CW-1:0] box_max_x;
        logic signed [CW-1:0] box_max_y;
        logic signed [CW-1:0] box_max_z;
    } t_box;

    // transformed vertex as it travels through the queue
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 last;
    } t_point;

    typedef struct packed {
        logic [ROW_W-1:0] row_x;
        logic [ROW_W-1:0] row_y;
        logic [ROW_W-1:0] row_z;
    } t_rows;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_q_status;

    // saturate a wide signed value into the coordinate range
    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(CMAX);
        lo = SUM_W'(CMIN);
        if (v > hi) begin
            return CMAX;
        end else if (v < lo) begin
            return CMIN;
        end else begin
            return v[CW-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/taa_ifs.sv
// valid/ready channel interfaces for vertex beats and box beats
`default_nettype none

interface taa_vtx_if import taa_pkg::*; ();
    logic    valid;
    logic    ready;
    t_vertex payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface taa_box_if import taa_pkg::*; ();
    logic valid;
    logic ready;
    t_box payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/taa_front.sv
// front end: accepts vertices and runs the two-stage affine transform pipe
`default_nettype none

module taa_front import taa_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    taa_vtx_if.sink        i_vtx,
    input  wire t_rows     i_rows,
    input  wire t_q_status i_q_stat,
    output logic           o_push,
    output t_point         o_point
);

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_last1;
    logic signed [PROD_W-1:0] r_prod [NAXES][NAXES];
    logic signed [COEF_W-1:0] r_tr   [NAXES];
    t_point                   r_pt;

    logic signed [COEF_W-1:0] coef [NAXES][NTERMS];
    logic signed [IN_W-1:0]   vin  [NAXES];
    logic [ROW_W-1:0]         rows [NAXES];
    logic signed [SUM_W-1:0]  sum  [NAXES];
    logic signed [CW-1:0]     pt   [NAXES];
    logic [QCNT_W-1:0]        used;
    logic                     accept;

    // every beat in the pipe has a queue slot reserved
    assign used        = i_q_stat.count + QCNT_W'(r_v1) + QCNT_W'(r_v2);
    assign i_vtx.ready = (used < QCNT_W'(QDEPTH));
    assign accept      = i_vtx.valid && i_vtx.ready;

    always_comb begin
        rows[0] = i_rows.row_x;
        rows[1] = i_rows.row_y;
        rows[2] = i_rows.row_z;
        vin[0]  = i_vtx.payload.vertex_x;
        vin[1]  = i_vtx.payload.vertex_y;
        vin[2]  = i_vtx.payload.vertex_z;
        for (int a = 0; a < NAXES; a++) begin
            for (int k = 0; k < NTERMS; k++) begin
                coef[a][k] = rows[a][ROW_W-1-COEF_W*k -: COEF_W];
            end
        end
    end

    // stage 1: nine products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int a = 0; a < NAXES; a++) begin
                for (int k = 0; k < NAXES; k++) begin
                    r_prod[a][k] <= coef[a][k] * vin[k];
                end
                r_tr[a] <= coef[a][NTERMS-1];
            end
            r_last1 <= i_vtx.payload.last_vertex;
        end
    end

    // stage 2: sum, floor to q8.8, saturate
    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            sum[a] = SUM_W'(r_prod[a][0]) + SUM_W'(r_prod[a][1]) + SUM_W'(r_prod[a][2])
                   + (SUM_W'(r_tr[a]) <<< FRAC);
            pt[a]  = sat_coord(sum[a] >>> FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_pt <= '{x: pt[0], y: pt[1], z: pt[2], last: r_last1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    assign o_push  = r_v2;
    assign o_point = r_pt;

endmodule

`default_nettype wire

// File: hw/rtl/taa_queue.sv
// small queue of transformed vertices between front and back
`default_nettype none

module taa_queue import taa_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_point i_point,
    input  wire logic   i_pop,
    output t_point      o_head,
    output t_q_status   o_stat
);

    t_point            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

// File: hw/rtl/taa_back.sv
// back end: running min/max per axis, widening and the box output register
`default_nettype none

module taa_back import taa_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_point           i_head,
    input  wire t_q_status        i_q_stat,
    input  wire logic [EPS_W-1:0] i_eps,
    output logic                  o_pop,
    taa_box_if.source             o_box
);

    logic signed [CW-1:0] r_lo [NAXES];
    logic signed [CW-1:0] r_hi [NAXES];
    logic                 r_ov;
    t_box                 r_box;

    logic signed [CW-1:0]    p   [NAXES];
    logic signed [CW-1:0]    nlo [NAXES];
    logic signed [CW-1:0]    nhi [NAXES];
    logic signed [CW-1:0]    wlo [NAXES];
    logic signed [CW-1:0]    whi [NAXES];
    logic signed [SUM_W-1:0] eps;
    logic                    out_free;

    assign out_free = !r_ov || o_box.ready;
    // a last vertex waits until the output register can take the box
    assign o_pop    = !i_q_stat.empty && (!i_head.last || out_free);
    assign eps      = SUM_W'($signed({1'b0, i_eps}));

    always_comb begin
        p[0] = i_head.x;
        p[1] = i_head.y;
        p[2] = i_head.z;
        for (int a = 0; a < NAXES; a++) begin
            nlo[a] = (p[a] < r_lo[a]) ? p[a] : r_lo[a];
            nhi[a] = (p[a] > r_hi[a]) ? p[a] : r_hi[a];
            if (nlo[a] == nhi[a]) begin
                wlo[a] = sat_coord(SUM_W'(nlo[a]) - eps);
                whi[a] = sat_coord(SUM_W'(nhi[a]) + eps);
            end else begin
                wlo[a] = nlo[a];
                whi[a] = nhi[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            for (int a = 0; a < NAXES; a++) begin
                r_lo[a] <= CMAX;
                r_hi[a] <= CMIN;
            end
        end else begin
            if (o_pop && i_head.last) begin
                r_ov <= 1'b1;
                for (int a = 0; a < NAXES; a++) begin
                    r_lo[a] <= CMAX;
                    r_hi[a] <= CMIN;
                end
            end else begin
                if (o_box.ready) begin
                    r_ov <= 1'b0;
                end
                if (o_pop) begin
                    for (int a = 0; a < NAXES; a++) begin
                        r_lo[a] <= nlo[a];
                        r_hi[a] <= nhi[a];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_box <= '{box_min_x: wlo[0], box_min_y: wlo[1], box_min_z: wlo[2],
                       box_max_x: whi[0], box_max_y: whi[1], box_max_z: whi[2]};
        end
    end

    assign o_box.valid   = r_ov;
    assign o_box.payload = r_box;

endmodule

`default_nettype wire

// File: hw/rtl/transformed_aabb_accumulator_top.sv
// top level of the transformed axis-aligned bounding box accumulator
//
// channel   dir  beat                               flow control
// i_vtx     in   vertex x/y/z q8.8 + last marker    valid/ready
// o_box     out  box min/max per axis, q8.8         valid/ready
// i_cfg_*   in   register write (rows, epsilon)     write enable only
//
// one vertex per cycle sustained while the box output does not stall; box valid
// rises once the beat of its last vertex has passed the two transform stages
// (products, then sum and saturate), the queue and the box output register
// synchronous reset clears the pipe, the queue, the bounds and loads the
// identity transform with epsilon of 1
// an output stall holds only a last vertex at the queue head; the 4-deep
// queue absorbs the beats in flight, and input ready drops once the queue
// and the two pipe stages together hold four beats
`default_nettype none

module transformed_aabb_accumulator_top import taa_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    taa_vtx_if.sink                    i_vtx,
    taa_box_if.source                  o_box,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    t_rows            r_rows;
    logic [EPS_W-1:0] r_eps;

    // front to queue
    logic      push;
    t_point    push_pt;
    // queue to back
    t_point    head;
    t_q_status q_stat;
    logic      pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows.row_x <= ROW_X_RST;
            r_rows.row_y <= ROW_Y_RST;
            r_rows.row_z <= ROW_Z_RST;
            r_eps        <= EPS_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ROW_X: begin
                    r_rows.row_x <= i_cfg_data;
                end
                REG_ROW_Y: begin
                    r_rows.row_y <= i_cfg_data;
                end
                REG_ROW_Z: begin
                    r_rows.row_z <= i_cfg_data;
                end
                REG_EPSILON: begin
                    r_eps <= i_cfg_data[EPS_W-1:0];
                end
                default: begin
                    r_eps <= r_eps;
                end
            endcase
        end
    end

    // transform pipe, reserves a queue slot per beat in flight
    taa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vtx    (i_vtx),
        .i_rows   (r_rows),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_point  (push_pt)
    );

    taa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_point (push_pt),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // bounds update and box emission
    taa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .i_eps    (r_eps),
        .o_pop    (pop),
        .o_box    (o_box)
    );

endmodule

`default_nettype wire

// File: hw/rtl/taa_checker.sv
// port-level checker for the accumulator top and its bind
`default_nettype none

module taa_checker import taa_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_box_valid,
    input wire logic i_box_ready,
    input wire t_box i_box
);

    // a reset cycle leaves no box pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_box_valid)
        else $error("box valid right after reset");

    // a box covers at least one vertex, so min never exceeds max
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_box_valid |-> (i_box.box_min_x <= i_box.box_max_x)
                     && (i_box.box_min_y <= i_box.box_max_y)
                     && (i_box.box_min_z <= i_box.box_max_z))
        else $error("box min above max");

    // a stalled box beat holds
    a_box_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_box_valid && !i_box_ready |=> i_box_valid && $stable(i_box))
        else $error("stalled box beat changed");

endmodule

bind transformed_aabb_accumulator_top taa_checker u_taa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_box_valid (o_box.valid),
    .i_box_ready (o_box.ready),
    .i_box       (o_box.payload)
);

`default_nettype wire
